>>> design/assert_macros.svh
// Assertion helpers used by the console writer controller.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check an implication in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Check an implication in the same cycle.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`else

`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_SAME(lbl, ante, cons)

`endif

`endif

>>> design/tcw_pkg.sv
package tcw_pkg;

  // Grid geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths
  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int COLOUR_W  = 4;
  localparam int CFG_IDX_W = 1;

  // Character and cell constants
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  // Request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 1'd1;

  // Reset colours
  localparam logic [COLOUR_W-1:0] FG_RESET = 4'd0;
  localparam logic [COLOUR_W-1:0] BG_RESET = 4'd7;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture the incoming beat
    logic clr_step;  // write one blank cell of the reset sweep
    logic rd_issue;  // read the requested cell
    logic put_step;  // write the character, move the cursor
    logic prime;     // issue the first read of the scroll
    logic scr_step;  // move one cell up during the scroll
    logic load_out;  // load the result registers
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_is_read;
    logic need_scroll;
    logic w_last;
  } sts_t;

endpackage

>>> design/tcw_ctrl.sv
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          strobe_o,
  output tcw_pkg::cmd_t cmd_o,
  input  tcw_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_PUT,
    S_PRIME,
    S_SCROLL,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   strobe_q;
  logic   accept;

  assign accept   = (state_q == S_IDLE) && start_i;
  assign busy_o   = (state_q != S_IDLE);
  assign strobe_o = strobe_q;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.w_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_PUT;
        end
      end
      S_PUT: begin
        // the latched request type decides the branch
        if (sts_i.req_is_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_READ;
        end else begin
          cmd_o.put_step = 1'b1;
          state_d        = sts_i.need_scroll ? S_PRIME : S_FIN;
        end
      end
      S_READ: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_IDLE;
      end
      S_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = S_SCROLL;
      end
      S_SCROLL: begin
        cmd_o.scr_step = 1'b1;
        if (sts_i.w_last) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= cmd_o.load_out;
    end
  end

  `ASSERT_NEXT(a_strobe_single, strobe_q, !strobe_q)
  `ASSERT_NEXT(a_accept_busy, accept, busy_o)
  `ASSERT_NEXT(a_scroll_ends, (state_q == S_SCROLL) && sts_i.w_last, state_q == S_FIN)
  `ASSERT_SAME(a_no_strobe_busy_clear, state_q == S_CLEAR, !strobe_q)
  `ASSERT_NEXT(a_load_strobes, cmd_o.load_out, strobe_q)

endmodule

>>> design/tcw_datapath.sv
module tcw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcw_pkg::cmd_t                     cmd_i,
  output tcw_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcw_pkg::COLOUR_W-1:0]      cfg_wdata_i,
  input  logic                              req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]        cell_index_i,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col_o,
  output logic                              scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]        read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]        read_attr_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam logic [AW:0]    CELLS_X    = (AW+1)'(tcw_pkg::CELLS);
  localparam logic [AW-1:0]  LAST_CELL  = AW'(tcw_pkg::CELLS - 1);
  localparam logic [AW-1:0]  COLS_A     = AW'(tcw_pkg::COLUMNS);
  localparam logic [AW-1:0]  KEEP_LIMIT = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::COL_W:0] COLS_C = (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::ROW_W:0] ROWS_R = (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS);
  localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

  // Cell memory
  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  // Latched request
  logic                        req_q;
  logic [tcw_pkg::CHAR_W-1:0]  char_q;
  logic [AW-1:0]               idx_q;
  logic                        scr_flag_q;

  // Cursor, colours, sweep counter
  logic [tcw_pkg::ROW_W-1:0]    row_q;
  logic [tcw_pkg::COL_W-1:0]    col_q;
  logic [tcw_pkg::COLOUR_W-1:0] fg_q, bg_q;
  logic [AW-1:0]                w_q;

  // Put arithmetic
  logic                        is_nl, wrap, adv_row, idx_ok;
  logic [AW-1:0]               pos;
  logic [tcw_pkg::COL_W:0]     col_inc;
  logic [tcw_pkg::ROW_W:0]     row_inc;
  logic [tcw_pkg::ATTR_W-1:0]  attr;
  logic [AW:0]                 scr_raddr;

  assign attr    = {fg_q, bg_q};
  assign is_nl   = (char_q == tcw_pkg::NEWLINE_CODE);
  assign pos     = AW'(row_q) * COLS_A + AW'(col_q);
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign wrap    = (col_inc >= COLS_C);
  assign adv_row = is_nl || wrap;
  assign row_inc = {1'b0, row_q} + {{tcw_pkg::ROW_W{1'b0}}, adv_row};
  assign idx_ok  = ({1'b0, idx_q} < CELLS_X);
  assign scr_raddr = {1'b0, w_q} + (AW+1)'(tcw_pkg::COLUMNS + 1);

  assign sts_o.req_is_read = (req_q == tcw_pkg::REQ_READ);
  assign sts_o.need_scroll = (row_inc >= ROWS_R);
  assign sts_o.w_last      = (w_q == LAST_CELL);

  // Route memory write and read
  always_comb begin
    mem_we    = cmd_i.clr_step || cmd_i.scr_step || (cmd_i.put_step && !is_nl);
    mem_waddr = cmd_i.put_step ? pos : w_q;
    if (cmd_i.clr_step) begin
      mem_wdata = tcw_pkg::BLANK_CELL;
    end else if (cmd_i.put_step) begin
      mem_wdata = {attr, char_q};
    end else if (w_q < KEEP_LIMIT) begin
      mem_wdata = rdata_q;
    end else begin
      mem_wdata = {attr, {tcw_pkg::CHAR_W{1'b0}}};
    end
    if (cmd_i.rd_issue) begin
      mem_raddr = idx_q;
      mem_re    = idx_ok;
    end else if (cmd_i.prime) begin
      mem_raddr = COLS_A;
      mem_re    = 1'b1;
    end else begin
      mem_raddr = scr_raddr[AW-1:0];
      mem_re    = cmd_i.scr_step && (scr_raddr < CELLS_X);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // Capture the request beat and the scroll flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q      <= req_type_i;
      char_q     <= char_code_i;
      idx_q      <= cell_index_i;
      scr_flag_q <= 1'b0;
    end else if (cmd_i.put_step) begin
      scr_flag_q <= sts_o.need_scroll;
    end
  end

  // Advance cursor, colours and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      fg_q  <= tcw_pkg::FG_RESET;
      bg_q  <= tcw_pkg::BG_RESET;
      w_q   <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == tcw_pkg::CFG_FOREGROUND)) fg_q <= cfg_wdata_i;
      if (cfg_we_i && (cfg_idx_i == tcw_pkg::CFG_BACKGROUND)) bg_q <= cfg_wdata_i;
      if (cmd_i.put_step) begin
        col_q <= adv_row ? '0 : col_inc[tcw_pkg::COL_W-1:0];
        row_q <= sts_o.need_scroll ? ROW_LAST : row_inc[tcw_pkg::ROW_W-1:0];
      end
      if (cmd_i.prime) begin
        w_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.scr_step) begin
        w_q <= sts_o.w_last ? '0 : w_q + 1'b1;
      end
    end
  end

  // Load the result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cursor_row_o <= row_q;
      cursor_col_o <= col_q;
      scrolled_o   <= scr_flag_q;
      if ((req_q == tcw_pkg::REQ_READ) && idx_ok) begin
        read_char_o <= rdata_q[tcw_pkg::CHAR_W-1:0];
        read_attr_o <= rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end else begin
        read_char_o <= '0;
        read_attr_o <= '0;
      end
    end
  end

endmodule

>>> design/text_console_writer.sv
// Text console writer: an 80 x 25 grid of cells, each a character byte and
// an attribute byte (foreground << 4 | background).
// Request channel: drive req_type_i, char_code_i and cell_index_i with start
// high; the beat is taken at a clock edge where busy is low. A put writes the
// character at the cursor (newline only moves the cursor) and advances it; a
// read returns one cell.
// Result channel: out_valid_o is high for exactly one cycle with the cursor,
// the scroll flag and the read cell. The receiver cannot stall it.
// A read or a put without scroll goes through S_PUT and then S_READ or S_FIN,
// with busy high in both; the result is registered as busy falls, so a new
// beat is taken only once the last is through. A put that scrolls moves the
// grid up one row in S_PRIME and S_SCROLL, one cell per cycle.
// Colour registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must write them only while busy is low, as the block does not
// enforce it. A write takes effect at once. Reset: the cursor goes to row 0,
// column 0, colours to 0 and 7, and a clearing pass writes a blank (0x0720)
// to every cell, one per cycle; busy stays high during the pass.
module text_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcw_pkg::COLOUR_W-1:0]      cfg_wdata_i,
  input  logic                              req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]        cell_index_i,
  output logic                              out_valid_o,
  output logic [tcw_pkg::ROW_W-1:0]         cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col_o,
  output logic                              scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]        read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]        read_attr_o
);

  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;

  // Sequence the work
  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .strobe_o (out_valid_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // Hold cells, cursor and colours
  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o)
  );

endmodule
